// ===== rtl/core/nrm_pkg.sv =====
`timescale 1ns / 1ps
package nrm_pkg;

    localparam int DEF_UNIT_SCALE = 1024;
    localparam int DEF_COORD_BITS = 24;
    localparam int NCOMP          = 3;
    localparam int OUT_BITS       = 12;
    localparam int OUT_POS_MAX    = 2047;
    localparam int OUT_NEG_MAX    = 2048;

    typedef struct packed {
        logic             valid;
        logic             deg;
        logic [NCOMP-1:0] neg;
    } t_ctl;

endpackage

// ===== rtl/core/nrm_cell.sv =====
`timescale 1ns / 1ps
module nrm_cell #(
    parameter int BIT        = 0,
    parameter int NB         = 11,
    parameter int SB         = 102,
    parameter int PW         = 124,
    parameter int UNIT_SCALE = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  nrm_pkg::t_ctl        i_ctl,
    input  logic [SB-1:0]        i_s,
    input  logic [PW-1:0]        i_t [nrm_pkg::NCOMP],
    input  logic [PW-1:0]        i_p [nrm_pkg::NCOMP],
    input  logic [PW-1:0]        i_q [nrm_pkg::NCOMP],
    input  logic [NB-1:0]        i_n [nrm_pkg::NCOMP],
    output nrm_pkg::t_ctl        o_ctl,
    output logic [SB-1:0]        o_s,
    output logic [PW-1:0]        o_t [nrm_pkg::NCOMP],
    output logic [PW-1:0]        o_p [nrm_pkg::NCOMP],
    output logic [PW-1:0]        o_q [nrm_pkg::NCOMP],
    output logic [NB-1:0]        o_n [nrm_pkg::NCOMP]
);
    import nrm_pkg::*;

    logic [PW-1:0]    n_p [NCOMP];
    logic [PW-1:0]    n_q [NCOMP];
    logic [NB-1:0]    n_n [NCOMP];
    logic             r_valid;
    logic             r_deg;
    logic [NCOMP-1:0] r_neg;

    // one bit of the restoring search: n*n*S <= T, kept as P = n*n*S, Q = n*S
    always_comb begin
        logic [NB-1:0] cand;
        logic [PW-1:0] trial;
        for (int c = 0; c < NCOMP; c++) begin
            cand  = i_n[c] | (NB'(1) << BIT);
            trial = i_p[c] + (i_q[c] << (BIT + 1)) + (PW'(i_s) << (2 * BIT));
            if (cand <= NB'(UNIT_SCALE) && trial <= i_t[c]) begin
                n_p[c] = trial;
                n_q[c] = i_q[c] + (PW'(i_s) << BIT);
                n_n[c] = cand;
            end else begin
                n_p[c] = i_p[c];
                n_q[c] = i_q[c];
                n_n[c] = i_n[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_deg <= i_ctl.deg;
            r_neg <= i_ctl.neg;
            o_s   <= i_s;
            o_t   <= i_t;
            o_p   <= n_p;
            o_q   <= n_q;
            o_n   <= n_n;
        end
    end

    assign o_ctl = '{valid: r_valid, deg: r_deg, neg: r_neg};

endmodule

// ===== rtl/core/triangle_face_normal.sv =====
`timescale 1ns / 1ps
// path: the stage registers, then a row of search cells, one per result bit, then the output register
// throughput: one triangle per cycle; the search runs one result bit per cell in a
// pipelined row of cells, and the whole pipeline holds only while a result waits
// reset: synchronous active-low, clears the stage valid bits and the output valid
module triangle_face_normal #(
    parameter int UNIT_SCALE = nrm_pkg::DEF_UNIT_SCALE,
    parameter int COORD_BITS = nrm_pkg::DEF_COORD_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [COORD_BITS-1:0]         i_v0_x,
    input  logic signed [COORD_BITS-1:0]         i_v0_y,
    input  logic signed [COORD_BITS-1:0]         i_v0_z,
    input  logic signed [COORD_BITS-1:0]         i_v1_x,
    input  logic signed [COORD_BITS-1:0]         i_v1_y,
    input  logic signed [COORD_BITS-1:0]         i_v1_z,
    input  logic signed [COORD_BITS-1:0]         i_v2_x,
    input  logic signed [COORD_BITS-1:0]         i_v2_y,
    input  logic signed [COORD_BITS-1:0]         i_v2_z,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [nrm_pkg::OUT_BITS-1:0]  o_normal_x,
    output logic signed [nrm_pkg::OUT_BITS-1:0]  o_normal_y,
    output logic signed [nrm_pkg::OUT_BITS-1:0]  o_normal_z,
    output logic                                 o_degenerate
);
    import nrm_pkg::*;

    localparam int EB  = COORD_BITS + 1;
    localparam int PB  = 2 * EB;
    localparam int CB  = PB + 1;
    localparam int MB  = PB;
    localparam int HB  = (MB + 1) / 2;
    localparam int GB  = MB - HB;
    localparam int SQB = 2 * MB;
    localparam int SB  = SQB + 2;
    localparam int NB  = $clog2(UNIT_SCALE + 1);
    localparam int XB  = MB + NB;
    localparam int LB  = (XB + 2) / 3;
    localparam int PW  = 2 * NB + SB;
    localparam int SW  = (NB > OUT_BITS ? NB : OUT_BITS) + 1;

    logic en;

    // edges and cross product partial products
    logic signed [EB-1:0] ea [NCOMP];
    logic signed [EB-1:0] eb [NCOMP];
    logic signed [PB-1:0] r1_pa [NCOMP];
    logic signed [PB-1:0] r1_pb [NCOMP];
    logic                 r1_valid;

    always_comb begin
        ea[0] = EB'(i_v1_x) - EB'(i_v0_x);
        ea[1] = EB'(i_v1_y) - EB'(i_v0_y);
        ea[2] = EB'(i_v1_z) - EB'(i_v0_z);
        eb[0] = EB'(i_v2_x) - EB'(i_v0_x);
        eb[1] = EB'(i_v2_y) - EB'(i_v0_y);
        eb[2] = EB'(i_v2_z) - EB'(i_v0_z);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pa[0] <= ea[1] * eb[2];
            r1_pb[0] <= eb[1] * ea[2];
            r1_pa[1] <= ea[2] * eb[0];
            r1_pb[1] <= eb[2] * ea[0];
            r1_pa[2] <= ea[0] * eb[1];
            r1_pb[2] <= eb[0] * ea[1];
        end
    end

    // cross product, sign and magnitude
    logic signed [CB-1:0] cr [NCOMP];
    logic [MB-1:0]        r2_mag [NCOMP];
    t_ctl                 r2_ctl;
    logic [NCOMP-1:0]     neg2;

    always_comb begin
        for (int c = 0; c < NCOMP; c++) begin
            cr[c]   = CB'(r1_pa[c]) - CB'(r1_pb[c]);
            neg2[c] = cr[c][CB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NCOMP; c++) begin
                r2_mag[c] <= neg2[c] ? MB'(-cr[c]) : MB'(cr[c]);
            end
            r2_ctl.neg <= neg2;
            r2_ctl.deg <= (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
        end
    end

    // partial products of the squares and of magnitude times unit
    logic [2*GB-1:0]  r3_hh [NCOMP];
    logic [GB+HB-1:0] r3_hl [NCOMP];
    logic [2*HB-1:0]  r3_ll [NCOMP];
    logic [GB+NB-1:0] r3_hu [NCOMP];
    logic [HB+NB-1:0] r3_lu [NCOMP];
    t_ctl             r3_ctl;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NCOMP; c++) begin
                r3_hh[c] <= r2_mag[c][MB-1:HB] * r2_mag[c][MB-1:HB];
                r3_hl[c] <= r2_mag[c][MB-1:HB] * r2_mag[c][HB-1:0];
                r3_ll[c] <= r2_mag[c][HB-1:0] * r2_mag[c][HB-1:0];
                r3_hu[c] <= r2_mag[c][MB-1:HB] * NB'(UNIT_SCALE);
                r3_lu[c] <= r2_mag[c][HB-1:0] * NB'(UNIT_SCALE);
            end
            r3_ctl.neg <= r2_ctl.neg;
            r3_ctl.deg <= r2_ctl.deg;
        end
    end

    logic [SQB-1:0] r4_sq [NCOMP];
    logic [XB-1:0]  r4_x  [NCOMP];
    t_ctl           r4_ctl;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < NCOMP; c++) begin
                r4_sq[c] <= (SQB'(r3_hh[c]) << (2 * HB)) + (SQB'(r3_hl[c]) << (HB + 1))
                          + SQB'(r3_ll[c]);
                r4_x[c]  <= (XB'(r3_hu[c]) << HB) + XB'(r3_lu[c]);
            end
            r4_ctl.neg <= r3_ctl.neg;
            r4_ctl.deg <= r3_ctl.deg;
        end
    end

    // sum of squares and limb products of (magnitude times unit) squared
    logic [3*LB-1:0] xw [NCOMP];
    logic [SB-1:0]   r5_s;
    logic [2*LB-1:0] r5_aa [NCOMP];
    logic [2*LB-1:0] r5_bb [NCOMP];
    logic [2*LB-1:0] r5_cc [NCOMP];
    logic [2*LB-1:0] r5_ab [NCOMP];
    logic [2*LB-1:0] r5_ac [NCOMP];
    logic [2*LB-1:0] r5_bc [NCOMP];
    t_ctl            r5_ctl;

    always_comb begin
        for (int c = 0; c < NCOMP; c++) begin
            xw[c] = (3 * LB)'(r4_x[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_s <= SB'(r4_sq[0]) + SB'(r4_sq[1]) + SB'(r4_sq[2]);
            for (int c = 0; c < NCOMP; c++) begin
                r5_aa[c] <= xw[c][3*LB-1:2*LB] * xw[c][3*LB-1:2*LB];
                r5_bb[c] <= xw[c][2*LB-1:LB] * xw[c][2*LB-1:LB];
                r5_cc[c] <= xw[c][LB-1:0] * xw[c][LB-1:0];
                r5_ab[c] <= xw[c][3*LB-1:2*LB] * xw[c][2*LB-1:LB];
                r5_ac[c] <= xw[c][3*LB-1:2*LB] * xw[c][LB-1:0];
                r5_bc[c] <= xw[c][2*LB-1:LB] * xw[c][LB-1:0];
            end
            r5_ctl.neg <= r4_ctl.neg;
            r5_ctl.deg <= r4_ctl.deg;
        end
    end

    logic [SB-1:0] r6_s;
    logic [PW-1:0] r6_t [NCOMP];
    t_ctl          r6_ctl;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_s <= r5_s;
            for (int c = 0; c < NCOMP; c++) begin
                r6_t[c] <= (PW'(r5_aa[c]) << (4 * LB)) + (PW'(r5_ab[c]) << (3 * LB + 1))
                         + (PW'(r5_bb[c]) << (2 * LB)) + (PW'(r5_ac[c]) << (2 * LB + 1))
                         + (PW'(r5_bc[c]) << (LB + 1)) + PW'(r5_cc[c]);
            end
            r6_ctl.neg <= r5_ctl.neg;
            r6_ctl.deg <= r5_ctl.deg;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid     <= 1'b0;
            r2_ctl.valid <= 1'b0;
            r3_ctl.valid <= 1'b0;
            r4_ctl.valid <= 1'b0;
            r5_ctl.valid <= 1'b0;
            r6_ctl.valid <= 1'b0;
        end else if (en) begin
            r1_valid     <= i_valid;
            r2_ctl.valid <= r1_valid;
            r3_ctl.valid <= r2_ctl.valid;
            r4_ctl.valid <= r3_ctl.valid;
            r5_ctl.valid <= r4_ctl.valid;
            r6_ctl.valid <= r5_ctl.valid;
        end
    end

    // row of search cells, most significant result bit first
    t_ctl          w_ctl [NB+1];
    logic [SB-1:0] w_s   [NB+1];
    logic [PW-1:0] w_t   [NB+1][NCOMP];
    logic [PW-1:0] w_p   [NB+1][NCOMP];
    logic [PW-1:0] w_q   [NB+1][NCOMP];
    logic [NB-1:0] w_n   [NB+1][NCOMP];

    assign w_ctl[0] = r6_ctl;
    assign w_s[0]   = r6_s;
    for (genvar c = 0; c < NCOMP; c++) begin : g_head
        assign w_t[0][c] = r6_t[c];
        assign w_p[0][c] = '0;
        assign w_q[0][c] = '0;
        assign w_n[0][c] = '0;
    end

    for (genvar k = 0; k < NB; k++) begin : g_cell
        nrm_cell #(
            .BIT       (NB - 1 - k),
            .NB        (NB),
            .SB        (SB),
            .PW        (PW),
            .UNIT_SCALE(UNIT_SCALE)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_ctl  (w_ctl[k]),
            .i_s    (w_s[k]),
            .i_t    (w_t[k]),
            .i_p    (w_p[k]),
            .i_q    (w_q[k]),
            .i_n    (w_n[k]),
            .o_ctl  (w_ctl[k+1]),
            .o_s    (w_s[k+1]),
            .o_t    (w_t[k+1]),
            .o_p    (w_p[k+1]),
            .o_q    (w_q[k+1]),
            .o_n    (w_n[k+1])
        );
    end

    // saturation, sign and output register
    logic [SW-1:0]       mag_lim [NCOMP];
    logic [SW-1:0]       mag_ext [NCOMP];
    logic [SW-1:0]       mag_sat [NCOMP];
    logic [OUT_BITS-1:0] comp    [NCOMP];
    t_ctl                fin;
    logic                r_valid;

    assign fin = w_ctl[NB];

    always_comb begin
        for (int c = 0; c < NCOMP; c++) begin
            mag_ext[c] = SW'(w_n[NB][c]);
            mag_lim[c] = fin.neg[c] ? SW'(OUT_NEG_MAX) : SW'(OUT_POS_MAX);
            mag_sat[c] = (mag_ext[c] > mag_lim[c]) ? mag_lim[c] : mag_ext[c];
            if (fin.deg) begin
                comp[c] = '0;
            end else if (fin.neg[c]) begin
                comp[c] = OUT_BITS'(-mag_sat[c]);
            end else begin
                comp[c] = OUT_BITS'(mag_sat[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= fin.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_normal_x   <= comp[0];
            o_normal_y   <= comp[1];
            o_normal_z   <= comp[2];
            o_degenerate <= fin.deg;
        end
    end

    assign o_valid = r_valid;
    assign o_stall = r_valid && i_stall;
    assign en      = !o_stall;

`ifndef SYNTHESIS
    a_deg_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0)
        else $error("degenerate transaction with non-zero normal");

    a_nondeg_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_degenerate |-> o_normal_x != '0 || o_normal_y != '0 || o_normal_z != '0)
        else $error("non-degenerate transaction with zero normal");

    a_stall_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no transaction waiting");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

    localparam int UNIT    = nrm_pkg::DEF_UNIT_SCALE;
    localparam int CB      = nrm_pkg::DEF_COORD_BITS;
    localparam int OB      = nrm_pkg::OUT_BITS;
    localparam int N_RAND  = 2000;
    localparam int DRAIN   = 60;

    typedef logic signed [CB-1:0] t_coord;
    typedef logic signed [159:0]  t_wide;

    typedef struct {
        t_coord c[9];
    } t_triangle;

    typedef struct {
        logic signed [OB-1:0] nx;
        logic signed [OB-1:0] ny;
        logic signed [OB-1:0] nz;
        logic                 deg;
    } t_normal;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, o_valid, i_stall;
    t_coord i_v0_x, i_v0_y, i_v0_z, i_v1_x, i_v1_y, i_v1_z, i_v2_x, i_v2_y, i_v2_z;
    logic signed [OB-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic o_degenerate;

    t_triangle pending_tris[$];
    t_normal   expected_normals[$];
    int        n_presented, n_taken, n_results, n_errors, n_degenerate;
    int        pause_at;
    bit        stim_done;

    triangle_face_normal u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_v0_x(i_v0_x), .i_v0_y(i_v0_y), .i_v0_z(i_v0_z),
        .i_v1_x(i_v1_x), .i_v1_y(i_v1_y), .i_v1_z(i_v1_z),
        .i_v2_x(i_v2_x), .i_v2_y(i_v2_y), .i_v2_z(i_v2_z),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_degenerate(o_degenerate)
    );

    // magnitude n: largest with n*n*S <= comp*comp*UNIT*UNIT
    function automatic logic signed [OB-1:0] scale_component(t_wide comp, t_wide sumsq);
        t_wide mag, target, cand;
        logic [31:0] n;
        n = 0;
        mag = (comp < 0) ? -comp : comp;
        target = mag * mag * UNIT * UNIT;
        for (int b = 17; b >= 0; b--) begin
            cand = t_wide'(n | (32'd1 << b));
            if (cand <= UNIT && cand * cand * sumsq <= target)
                n = cand[31:0];
        end
        if (comp < 0) begin
            if (n > nrm_pkg::OUT_NEG_MAX) n = nrm_pkg::OUT_NEG_MAX;
            return OB'(-n);
        end
        if (n > nrm_pkg::OUT_POS_MAX) n = nrm_pkg::OUT_POS_MAX;
        return OB'(n);
    endfunction

    function automatic t_normal face_normal(t_triangle t);
        t_wide e1[3], e2[3], cr[3], sumsq;
        t_normal r;
        for (int i = 0; i < 3; i++) begin
            e1[i] = t_wide'(t.c[3+i]) - t_wide'(t.c[i]);
            e2[i] = t_wide'(t.c[6+i]) - t_wide'(t.c[i]);
        end
        cr[0] = e1[1] * e2[2] - e2[1] * e1[2];
        cr[1] = e1[2] * e2[0] - e2[2] * e1[0];
        cr[2] = e1[0] * e2[1] - e2[0] * e1[1];
        sumsq = cr[0] * cr[0] + cr[1] * cr[1] + cr[2] * cr[2];
        if (sumsq == 0) begin
            r.nx = '0; r.ny = '0; r.nz = '0; r.deg = 1'b1;
        end else begin
            r.nx = scale_component(cr[0], sumsq);
            r.ny = scale_component(cr[1], sumsq);
            r.nz = scale_component(cr[2], sumsq);
            r.deg = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on result %0d: %s got %0d expected %0d", n_results, what, got, want);
        n_errors++;
    endtask

    function automatic t_coord rand_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($signed($urandom_range(0, 64)) - 32);
            2: return ($urandom_range(0, 1)) ? t_coord'(24'h7fffff) : t_coord'(24'h800000);
            default: return t_coord'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    task automatic add_tri(t_coord a0, a1, a2, b0, b1, b2, d0, d1, d2);
        t_triangle t;
        t.c = '{a0, a1, a2, b0, b1, b2, d0, d1, d2};
        pending_tris.push_back(t);
    endtask

    task automatic add_random_tri();
        t_triangle t;
        int mode, k;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
            t.c[i] = rand_coord(mode < 5 ? 0 : (mode < 7 ? 3 : (mode < 8 ? 1 : 2)));
        // collinear or repeated vertices
        if (mode == 9) begin
            k = $signed($urandom_range(0, 6)) - 3;
            for (int i = 0; i < 3; i++) begin
                t.c[i] = rand_coord(3);
                t.c[3+i] = rand_coord(1);
                t.c[6+i] = t_coord'(t.c[i] + k * (t.c[3+i] - t.c[i]));
            end
        end
        pending_tris.push_back(t);
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
    end

    initial begin
        #5ms;
        $display("timeout with %0d results outstanding", expected_normals.size());
        $display("** triangle_face_normal: FAILED **");
        $finish;
    end

    // driver
    bit drv_busy;
    int drv_gap, no_idle;
    always @(negedge i_clk) begin
        t_triangle t;
        logic nv;
        nv = i_valid;
        if (drv_busy && n_taken == n_presented) begin
            drv_busy = 0;
            nv = 0;
            drv_gap = no_idle ? 0 : $urandom_range(0, 6);
        end
        if (!drv_busy && i_rst_n) begin
            if (drv_gap > 0) begin
                drv_gap--;
            end else if (pending_tris.size() > 0 &&
                         !(n_presented == pause_at && expected_normals.size() > 0)) begin
                t = pending_tris.pop_front();
                {i_v0_x, i_v0_y, i_v0_z} <= {t.c[0], t.c[1], t.c[2]};
                {i_v1_x, i_v1_y, i_v1_z} <= {t.c[3], t.c[4], t.c[5]};
                {i_v2_x, i_v2_y, i_v2_z} <= {t.c[6], t.c[7], t.c[8]};
                nv = 1;
                drv_busy = 1;
                n_presented++;
                if (n_presented % 400 == 0) no_idle = !no_idle;
            end
        end
        i_valid <= nv;
    end

    // receiver stall
    int rx_seen, rx_wait;
    always @(negedge i_clk) begin
        if (rx_seen != n_results) begin
            rx_seen = n_results;
            rx_wait = no_idle ? 0 : $urandom_range(0, 6);
        end
        if (rx_wait > 0) begin
            rx_wait--;
            i_stall <= 1;
        end else begin
            i_stall <= 0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_triangle t;
        t_normal e;
        if (i_rst_n && i_valid && !o_stall) begin
            t.c = '{i_v0_x, i_v0_y, i_v0_z, i_v1_x, i_v1_y, i_v1_z, i_v2_x, i_v2_y, i_v2_z};
            expected_normals.push_back(face_normal(t));
            n_taken++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_normals.size() == 0) begin
                $display("unexpected result %0d", n_results);
                n_errors++;
            end else begin
                e = expected_normals.pop_front();
                if (o_normal_x !== e.nx) report_mismatch("normal_x", o_normal_x, e.nx);
                if (o_normal_y !== e.ny) report_mismatch("normal_y", o_normal_y, e.ny);
                if (o_normal_z !== e.nz) report_mismatch("normal_z", o_normal_z, e.nz);
                if (o_degenerate !== e.deg) report_mismatch("degenerate", o_degenerate, e.deg);
                if (e.deg) n_degenerate++;
            end
            n_results++;
        end
    end

    initial begin
        t_coord mx, mn;
        mx = 24'h7fffff;
        mn = 24'h800000;
        i_valid = 0; i_stall = 0;
        {i_v0_x, i_v0_y, i_v0_z, i_v1_x, i_v1_y, i_v1_z, i_v2_x, i_v2_y, i_v2_z} = '0;
        n_presented = 0; n_taken = 0; n_results = 0; n_errors = 0; n_degenerate = 0;
        drv_busy = 0; drv_gap = 0; no_idle = 0; rx_seen = 0; rx_wait = 0;
        pause_at = 300;

        // all-zero and repeated vertices
        add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_tri(5, 6, 7, 5, 6, 7, -1, 2, 3);
        // axis-aligned faces
        add_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);
        add_tri(0, 0, 0, 0, 1, 0, 1, 0, 0);
        add_tri(0, 0, 0, 0, 1, 0, 0, 0, 1);
        add_tri(0, 0, 0, 0, 0, 1, 1, 0, 0);
        add_tri(0, 0, 0, 0, 0, 1, 0, 1, 0);
        add_tri(0, 0, 0, 1, 0, 0, 0, 0, 1);
        // extremes of the coordinate range
        add_tri(mn, mn, mn, mx, mn, mn, mn, mx, mn);
        add_tri(mx, mx, mx, mn, mx, mx, mx, mn, mx);
        add_tri(mn, mx, mn, mx, mn, mx, mn, mn, mx);
        add_tri(mx, mn, mn, mn, mx, mn, mn, mn, mx);
        add_tri(mn, mn, mn, mx, mx, mx, mn, mn, mn);
        add_tri(mn, mn, mn, mx, mx, mx, 0, 0, 0);
        add_tri(-1, -1, -1, 1, 1, 1, 3, 3, 3);
        // diagonal and off-axis normals
        add_tri(1, 0, 0, 0, 1, 0, 0, 0, 1);
        add_tri(mx, 0, 0, 0, mx, 0, 0, 0, mx);
        add_tri(mn, 0, 0, 0, mn, 0, 0, 0, mn);
        add_tri(0, 0, 0, mx, mx, 0, mn, mx, 1);
        add_tri(3, -7, 11, -2, 9, 4, 8, 1, -6);
        for (int i = 0; i < N_RAND; i++) add_random_tri();

        wait (pending_tris.size() == 0 && !drv_busy);
        wait (expected_normals.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        $display("%0d triangles sent, %0d normals checked, %0d degenerate",
                 n_taken, n_results, n_degenerate);
        if (n_errors == 0 && expected_normals.size() == 0)
            $display("** triangle_face_normal: PASSED **");
        else
            $display("** triangle_face_normal: FAILED **");
        $finish;
    end

endmodule
